// ----- src/dsvc_pkg.sv -----
// Shared types and constants for the delayed supply valve controller.
package dsvc_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] ST_INACTIVE = 2'd0;
    localparam logic [1:0] ST_IDLE     = 2'd1;
    localparam logic [1:0] ST_DOPEN    = 2'd2;
    localparam logic [1:0] ST_DCLOSE   = 2'd3;

    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_SHOWER   = 2'd1;
    localparam logic [1:0] REQ_LOOP_LVL = 2'd2;
    localparam logic [1:0] REQ_COLD_LVL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_OPEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_OPEN   = 2'd2;

    localparam logic [CFG_W-1:0] CLOSE_DELAY_RST = 16'd0;
    localparam logic [CFG_W-1:0] NORMAL_OPEN_RST = 16'd200;
    localparam logic [CFG_W-1:0] LOOP_OPEN_RST   = 16'd4000;

    typedef struct packed {
        logic [1:0] mode;
        logic       valve;
        logic       was_active;
        logic       in_loop;
        logic       loop_full;
        logic       cold_full;
        logic       armed;
    } ctrl_flags_t;

    typedef struct packed {
        logic [1:0] ctrl_state;
        logic       valve_written;
        logic       valve_open;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] close_delay_ms;
        logic [CFG_W-1:0] normal_open_delay_ms;
        logic [CFG_W-1:0] loop_open_delay_ms;
    } cfg_regs_t;

endpackage

// ----- src/dsvc_step.sv -----
// Next-state and result logic for one beat of the valve controller.
module dsvc_step #(
    parameter int TIME_BITS = 16
) (
    input  dsvc_pkg::ctrl_flags_t  cur,
    input  logic [TIME_BITS-1:0]   delay_left,
    input  logic [TIME_BITS-1:0]   open_elapsed,
    input  dsvc_pkg::cfg_regs_t    cfg,
    input  logic [1:0]             req_type,
    input  logic                   shower_active,
    input  logic                   shower_in_loop,
    input  logic                   level_bit,
    output dsvc_pkg::ctrl_flags_t  nxt,
    output logic [TIME_BITS-1:0]   delay_left_next,
    output logic [TIME_BITS-1:0]   open_elapsed_next,
    output dsvc_pkg::result_t      res
);
    import dsvc_pkg::*;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    always_comb begin
        ctrl_flags_t          nx;
        logic [TIME_BITS-1:0] left_n;
        logic [TIME_BITS-1:0] el_n;
        logic [TIME_BITS-1:0] target;
        logic                 wr;
        logic                 full_before;

        nx          = cur;
        left_n      = delay_left;
        el_n        = open_elapsed;
        wr          = 1'b0;
        full_before = cur.loop_full | cur.cold_full;
        target      = TIME_BITS'(shower_in_loop ? cfg.loop_open_delay_ms
                                                : cfg.normal_open_delay_ms);

        case (req_type)
            REQ_TICK: begin
                if (nx.mode == ST_DOPEN && el_n != TIME_MAX) begin
                    el_n = el_n + TIME_BITS'(1);
                end
                if (nx.armed) begin
                    if (left_n <= TIME_BITS'(1)) begin
                        nx.armed = 1'b0;
                        if (nx.mode == ST_DOPEN) begin
                            nx.valve = 1'b1;
                            wr       = 1'b1;
                            nx.mode  = ST_IDLE;
                        end else if (nx.mode == ST_DCLOSE) begin
                            nx.valve = 1'b0;
                            wr       = 1'b1;
                            nx.mode  = ST_IDLE;
                        end
                    end else begin
                        left_n = left_n - TIME_BITS'(1);
                    end
                end
            end
            REQ_SHOWER: begin
                if (shower_active != nx.was_active) begin
                    nx.was_active = shower_active;
                    if (shower_active) begin
                        if (nx.mode == ST_INACTIVE) begin
                            nx.valve = ~full_before;
                            wr       = 1'b1;
                            nx.mode  = ST_IDLE;
                        end
                    end else if (nx.mode != ST_INACTIVE) begin
                        if (nx.mode inside {ST_DOPEN, ST_DCLOSE}) begin
                            nx.armed = 1'b0;
                        end
                        nx.valve = 1'b0;
                        wr       = 1'b1;
                        nx.mode  = ST_INACTIVE;
                    end
                end
                if (shower_in_loop != nx.in_loop) begin
                    nx.in_loop = shower_in_loop;
                    if (nx.mode == ST_DOPEN) begin
                        if (el_n >= target) begin
                            nx.valve = 1'b1;
                            wr       = 1'b1;
                            nx.armed = 1'b0;
                            nx.mode  = ST_IDLE;
                        end else begin
                            left_n   = target - el_n;
                            nx.armed = 1'b1;
                        end
                    end
                end
            end
            REQ_LOOP_LVL, REQ_COLD_LVL: begin
                if (req_type == REQ_LOOP_LVL) begin
                    nx.loop_full = level_bit;
                end else begin
                    nx.cold_full = level_bit;
                end
                if (full_before != (nx.loop_full | nx.cold_full)) begin
                    if (nx.mode == ST_IDLE) begin
                        nx.armed = 1'b1;
                        if (nx.loop_full | nx.cold_full) begin
                            nx.mode = ST_DCLOSE;
                            left_n  = TIME_BITS'(cfg.close_delay_ms);
                        end else begin
                            nx.mode = ST_DOPEN;
                            left_n  = TIME_BITS'(nx.in_loop ? cfg.loop_open_delay_ms
                                                            : cfg.normal_open_delay_ms);
                            el_n    = '0;
                        end
                    end else if (nx.mode inside {ST_DOPEN, ST_DCLOSE}) begin
                        nx.armed = 1'b0;
                        nx.mode  = ST_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase

        nxt                   = nx;
        delay_left_next       = left_n;
        open_elapsed_next     = el_n;
        res.valve_open        = nx.valve;
        res.valve_written     = wr;
        res.ctrl_state        = nx.mode;
    end

endmodule

// ----- src/delayed_supply_valve_controller_unit.sv -----
// Top level of the delayed supply valve controller: state, config and result registers.
//
// Input channel s_axis: one beat is one event. tuser carries the request kind
// (tick of one ms, shower update, loop level, cold level), tdata its bits.
// Result channel m_axis: exactly one beat per input beat, in order, carrying
// the valve command, whether a valve command was issued, and the state.
// The config port writes one delay register per cycle when cfg_wr_en is high;
// write only while no beat is in flight.
//
// A result is registered and appears in the cycle after its input beat is taken.
// Throughput: one beat per cycle unless a held result stalls the input; the whole
// event is handled by the step logic between the state registers and the result register.
// Stall: s_axis_tready stays high while the result register is empty or is
// being emptied in the same cycle; a held result blocks new input only.
// Reset (aresetn low, synchronous): state inactive, valve closed, timers
// cleared, delay registers back to 0 / 200 / 4000 ms, no result pending.
module delayed_supply_valve_controller_unit #(
    parameter int TIME_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // shower_active, shower_in_loop, level_bit
    input  logic [1:0]                         s_axis_tuser,  // req_type
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata,  // valve_open, valve_written, ctrl_state[1:0]
    input  logic                               cfg_wr_en,
    input  logic [dsvc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dsvc_pkg::CFG_W-1:0]         cfg_wdata
);
    import dsvc_pkg::*;

    ctrl_flags_t          flags_reg, flags_next;
    logic [TIME_BITS-1:0] delay_left_reg, delay_left_next;
    logic [TIME_BITS-1:0] open_elapsed_reg, open_elapsed_next;
    cfg_regs_t            cfg_reg;
    result_t              res_reg, res_next;
    logic                 out_valid_reg;
    logic                 in_fire;

    assign s_axis_tready = ~out_valid_reg | m_axis_tready;
    assign in_fire       = s_axis_tvalid & s_axis_tready;

    dsvc_step #(
        .TIME_BITS(TIME_BITS)
    ) u_step (
        .cur               (flags_reg),
        .delay_left        (delay_left_reg),
        .open_elapsed      (open_elapsed_reg),
        .cfg               (cfg_reg),
        .req_type          (s_axis_tuser),
        .shower_active     (s_axis_tdata[0]),
        .shower_in_loop    (s_axis_tdata[1]),
        .level_bit         (s_axis_tdata[2]),
        .nxt               (flags_next),
        .delay_left_next   (delay_left_next),
        .open_elapsed_next (open_elapsed_next),
        .res               (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.close_delay_ms       <= CLOSE_DELAY_RST;
            cfg_reg.normal_open_delay_ms <= NORMAL_OPEN_RST;
            cfg_reg.loop_open_delay_ms   <= LOOP_OPEN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CLOSE_DELAY: cfg_reg.close_delay_ms       <= cfg_wdata;
                CFG_NORMAL_OPEN: cfg_reg.normal_open_delay_ms <= cfg_wdata;
                CFG_LOOP_OPEN:   cfg_reg.loop_open_delay_ms   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg        <= '0;
            delay_left_reg   <= '0;
            open_elapsed_reg <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (in_fire) begin
                flags_reg        <= flags_next;
                delay_left_reg   <= delay_left_next;
                open_elapsed_reg <= open_elapsed_next;
                out_valid_reg    <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, res_reg};

endmodule

// ----- src/dsvc_checker.sv -----
// Port-level checks for the valve controller, bound to the top level.
module dsvc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    import dsvc_pkg::*;

    // a held result keeps its beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted beat produced no result");

    a_inactive_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[3:2] == ST_INACTIVE) |-> !m_axis_tdata[0])
        else $error("valve open while inactive");

endmodule

bind delayed_supply_valve_controller_unit dsvc_checker u_dsvc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/delayed_supply_valve_controller_unit_tb.sv -----
// Self-checking testbench for the delayed supply valve controller.
module delayed_supply_valve_controller_unit_tb;
    import dsvc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int STALL_LIMIT = 2000;

    typedef enum logic [2:0] {
        EV_TIMEOUT,
        EV_LEVEL,
        EV_ACTIVATE,
        EV_DEACTIVATE,
        EV_LOOP
    } valve_ev_e;

    typedef struct {
        logic [1:0] req;
        logic       act;
        logic       loop;
        logic       lvl;
    } valve_req_t;

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;  // shower_active, shower_in_loop, level_bit
    logic [1:0]           s_axis_tuser  = '0;  // req_type
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;        // valve_open, valve_written, ctrl_state[1:0]
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_wdata     = '0;

    delayed_supply_valve_controller_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // controller model state
    logic [1:0]  ctl_mode     = ST_INACTIVE;
    logic        valve_cmd    = 1'b0;
    logic        valve_wr     = 1'b0;
    logic        was_active   = 1'b0;
    logic        loop_mode    = 1'b0;
    logic        loop_full    = 1'b0;
    logic        cold_full    = 1'b0;
    logic        timer_armed  = 1'b0;
    logic [15:0] timer_left   = '0;
    logic [15:0] open_elapsed = '0;
    logic [15:0] close_ms     = CLOSE_DELAY_RST;
    logic [15:0] normal_ms    = NORMAL_OPEN_RST;
    logic [15:0] loop_ms      = LOOP_OPEN_RST;

    valve_req_t valve_req_q[$];
    result_t    valve_result_q[$];
    valve_req_t cur_req;
    result_t    exp_res;
    result_t    got_res;
    int         fail_count = 0;
    int         in_gap     = 0;
    int         out_gap    = 0;
    bit         in_calm    = 1'b0;
    bit         out_calm   = 1'b0;
    int         idle_cycles = 0;

    function automatic void set_valve(logic open);
        valve_cmd = open;
        valve_wr  = 1'b1;
    endfunction

    function automatic logic tank_full();
        return loop_full | cold_full;
    endfunction

    function automatic void valve_fsm(valve_ev_e ev);
        logic [1:0]  nxt;
        logic [15:0] target;
        nxt    = ctl_mode;
        target = loop_mode ? loop_ms : normal_ms;
        case (ctl_mode)
            ST_INACTIVE: begin
                if (ev == EV_ACTIVATE) nxt = ST_IDLE;
            end
            ST_IDLE: begin
                if (ev == EV_LEVEL) nxt = tank_full() ? ST_DCLOSE : ST_DOPEN;
                else if (ev == EV_DEACTIVATE) nxt = ST_INACTIVE;
            end
            ST_DOPEN: begin
                if (ev == EV_TIMEOUT) begin
                    set_valve(1'b1);
                    nxt = ST_IDLE;
                end else if (ev == EV_LEVEL) begin
                    nxt = ST_IDLE;
                end else if (ev == EV_DEACTIVATE) begin
                    nxt = ST_INACTIVE;
                end else if (ev == EV_LOOP) begin
                    if (open_elapsed >= target) begin
                        set_valve(1'b1);
                        nxt = ST_IDLE;
                    end else begin
                        timer_left  = target - open_elapsed;
                        timer_armed = 1'b1;
                    end
                end
            end
            default: begin
                if (ev == EV_TIMEOUT) begin
                    set_valve(1'b0);
                    nxt = ST_IDLE;
                end else if (ev == EV_LEVEL) begin
                    nxt = ST_IDLE;
                end else if (ev == EV_DEACTIVATE) begin
                    nxt = ST_INACTIVE;
                end
            end
        endcase
        if (nxt != ctl_mode) begin
            if (ctl_mode == ST_INACTIVE) set_valve(!tank_full());
            else if (ctl_mode == ST_DOPEN || ctl_mode == ST_DCLOSE) timer_armed = 1'b0;
            ctl_mode = nxt;
            case (ctl_mode)
                ST_INACTIVE: set_valve(1'b0);
                ST_DOPEN: begin
                    timer_left   = loop_mode ? loop_ms : normal_ms;
                    timer_armed  = 1'b1;
                    open_elapsed = '0;
                end
                ST_DCLOSE: begin
                    timer_left  = close_ms;
                    timer_armed = 1'b1;
                end
                default: ;
            endcase
        end
    endfunction

    function automatic result_t predict_valve(valve_req_t r);
        result_t res;
        logic    was_full;
        valve_wr = 1'b0;
        was_full = tank_full();
        case (r.req)
            REQ_TICK: begin
                if (ctl_mode == ST_DOPEN && open_elapsed != 16'hFFFF) open_elapsed++;
                if (timer_armed) begin
                    if (timer_left <= 16'd1) begin
                        timer_armed = 1'b0;
                        valve_fsm(EV_TIMEOUT);
                    end else begin
                        timer_left--;
                    end
                end
            end
            REQ_SHOWER: begin
                if (r.act != was_active) begin
                    was_active = r.act;
                    valve_fsm(r.act ? EV_ACTIVATE : EV_DEACTIVATE);
                end
                if (r.loop != loop_mode) begin
                    loop_mode = r.loop;
                    valve_fsm(EV_LOOP);
                end
            end
            REQ_LOOP_LVL: begin
                loop_full = r.lvl;
                if (was_full != tank_full()) valve_fsm(EV_LEVEL);
            end
            default: begin
                cold_full = r.lvl;
                if (was_full != tank_full()) valve_fsm(EV_LEVEL);
            end
        endcase
        res.valve_open    = valve_cmd;
        res.valve_written = valve_wr;
        res.ctrl_state    = ctl_mode;
        return res;
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic valve_req_t rand_req();
        valve_req_t r;
        int         w;
        w = $urandom_range(0, 99);
        if (w < 55) r.req = REQ_TICK;
        else if (w < 75) r.req = REQ_SHOWER;
        else if (w < 87) r.req = REQ_LOOP_LVL;
        else r.req = REQ_COLD_LVL;
        r.act  = ($urandom_range(0, 99) < 85);
        r.loop = 1'($urandom_range(0, 1));
        r.lvl  = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) in_calm = !in_calm;
            if (s_axis_tvalid && s_axis_tready) valve_result_q.push_back(predict_valve(cur_req));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (valve_req_q.size() != 0) begin
                    cur_req = valve_req_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'b0, cur_req.lvl, cur_req.loop, cur_req.act};
                    s_axis_tuser  <= cur_req.req;
                    in_gap = pick_gap(in_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
            if (m_axis_tvalid && m_axis_tready) begin
                if (valve_result_q.size() == 0) begin
                    $error("unexpected result beat, tdata %0h", m_axis_tdata);
                    fail_count++;
                end else begin
                    exp_res = valve_result_q.pop_front();
                    got_res = m_axis_tdata[3:0];
                    if (got_res.valve_open !== exp_res.valve_open) begin
                        $error("valve_open expected %0d got %0d",
                               exp_res.valve_open, got_res.valve_open);
                        fail_count++;
                    end
                    if (got_res.valve_written !== exp_res.valve_written) begin
                        $error("valve_written expected %0d got %0d",
                               exp_res.valve_written, got_res.valve_written);
                        fail_count++;
                    end
                    if (got_res.ctrl_state !== exp_res.ctrl_state) begin
                        $error("ctrl_state expected %0d got %0d",
                               exp_res.ctrl_state, got_res.ctrl_state);
                        fail_count++;
                    end
                    if (m_axis_tdata[7:4] !== 4'b0) begin
                        $error("tdata pad expected 0 got %0h", m_axis_tdata[7:4]);
                        fail_count++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!out_calm && $urandom_range(0, 3) == 0) out_gap = pick_gap(1'b0);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("delayed_supply_valve_controller_unit regression: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic add_req(logic [1:0] req, logic act, logic loop, logic lvl);
        valve_req_t r;
        r.req  = req;
        r.act  = act;
        r.loop = loop;
        r.lvl  = lvl;
        valve_req_q.push_back(r);
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (valve_req_q.size() != 0 || s_axis_tvalid || valve_result_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_CLOSE_DELAY: close_ms  = val;
            CFG_NORMAL_OPEN: normal_ms = val;
            CFG_LOOP_OPEN:   loop_ms   = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_delays(logic [CFG_W-1:0] c, logic [CFG_W-1:0] n, logic [CFG_W-1:0] l);
        write_reg(CFG_CLOSE_DELAY, c);
        write_reg(CFG_NORMAL_OPEN, n);
        write_reg(CFG_LOOP_OPEN, l);
    endtask

    task automatic run_random(int n);
        repeat (n) valve_req_q.push_back(rand_req());
        drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed sequence on reset delays (close 0, open 200 / 4000)
        add_req(REQ_TICK,     1'b0, 1'b0, 1'b0);  // tick while inactive
        add_req(REQ_SHOWER,   1'b0, 1'b1, 1'b0);  // loop change while inactive
        add_req(REQ_SHOWER,   1'b1, 1'b1, 1'b0);  // activate, valve opens
        add_req(REQ_SHOWER,   1'b1, 1'b1, 1'b1);  // unchanged shower bits
        add_req(REQ_LOOP_LVL, 1'b0, 1'b0, 1'b1);  // full -> delayed close, zero delay
        add_req(REQ_TICK,     1'b0, 1'b0, 1'b0);  // zero delay fires on next tick
        add_req(REQ_COLD_LVL, 1'b1, 1'b1, 1'b1);  // still full, no event
        add_req(REQ_LOOP_LVL, 1'b0, 1'b0, 1'b0);  // cold keeps tank full
        add_req(REQ_LOOP_LVL, 1'b0, 1'b0, 1'b0);  // same level again
        add_req(REQ_COLD_LVL, 1'b0, 1'b0, 1'b0);  // empty -> delayed open, loop delay
        add_req(REQ_TICK,     1'b1, 1'b1, 1'b1);
        add_req(REQ_TICK,     1'b0, 1'b0, 1'b0);
        add_req(REQ_SHOWER,   1'b1, 1'b0, 1'b0);  // retarget to normal delay
        add_req(REQ_SHOWER,   1'b0, 1'b0, 1'b0);  // deactivate from delayed open
        add_req(REQ_SHOWER,   1'b1, 1'b0, 1'b0);  // reactivate, tank empty
        add_req(REQ_COLD_LVL, 1'b0, 1'b0, 1'b1);  // delayed close
        add_req(REQ_SHOWER,   1'b0, 1'b0, 1'b0);  // deactivate from delayed close
        add_req(REQ_SHOWER,   1'b1, 1'b1, 1'b0);  // activate with tank full
        add_req(REQ_COLD_LVL, 1'b0, 1'b0, 1'b0);  // delayed open
        add_req(REQ_COLD_LVL, 1'b0, 1'b0, 1'b1);  // level change aborts open
        add_req(REQ_TICK,     1'b0, 1'b0, 1'b0);  // timer disarmed in idle
        add_req(REQ_LOOP_LVL, 1'b1, 1'b1, 1'b1);
        drain();
        run_random(100);

        set_delays(16'd0, 16'd0, 16'd0);
        run_random(150);

        set_delays(16'd60000, 16'd60000, 16'd60000);
        write_reg(CFG_UNUSED_IDX, 16'hFFFF);
        run_random(100);

        set_delays(16'd3, 16'hFFFF, 16'd2);
        run_random(150);

        repeat (3) begin
            set_delays(CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 12)),
                       CFG_W'($urandom_range(0, 12)));
            run_random(175);
        end

        if (fail_count == 0) begin
            $display("delayed_supply_valve_controller_unit regression: pass");
        end else begin
            $display("delayed_supply_valve_controller_unit regression: fail");
        end
        $finish;
    end

endmodule
